// ===== hw/rtl/amgt_pkg.sv =====
// Package: widths, codes and the microcode store for the graph traversal block.
`timescale 1ns / 1ps
`default_nettype none

package amgt_pkg;

    // Sizes
    localparam int MAX_VERTICES = 16;
    localparam int VTX_W        = 4;
    localparam int CNT_W        = 5;
    localparam int WORK_DEPTH   = 256;
    localparam int WORK_AW      = 8;
    localparam int PTR_W        = 9;

    typedef logic [MAX_VERTICES-1:0] t_row;
    typedef logic [VTX_W-1:0]        t_vtx;

    // Input func codes
    localparam logic [2:0] FN_SET_EDGE = 3'd0;
    localparam logic [2:0] FN_CLR_EDGE = 3'd1;
    localparam logic [2:0] FN_BFS      = 3'd2;
    localparam logic [2:0] FN_DFS      = 3'd3;
    localparam logic [2:0] FN_ACTIVATE = 3'd4;
    localparam logic [2:0] FN_DEACT    = 3'd5;

    // Result status codes
    localparam logic [1:0] ST_VISIT  = 2'd0;
    localparam logic [1:0] ST_ACK    = 2'd1;
    localparam logic [1:0] ST_BADVTX = 2'd2;
    localparam logic [1:0] ST_ABSENT = 2'd3;

    // Configuration register indexes
    localparam logic CFG_DIRECTED = 1'b0;
    localparam logic CFG_COUNT    = 1'b1;

    // Datapath operations
    localparam logic [4:0] OP_NONE       = 5'd0;
    localparam logic [4:0] OP_LATCH      = 5'd1;
    localparam logic [4:0] OP_EMIT_ERR   = 5'd2;
    localparam logic [4:0] OP_EMIT_ACK   = 5'd3;
    localparam logic [4:0] OP_EMIT_ABS   = 5'd4;
    localparam logic [4:0] OP_WR_ACTIVE  = 5'd5;
    localparam logic [4:0] OP_RD_A       = 5'd6;
    localparam logic [4:0] OP_RD_B       = 5'd7;
    localparam logic [4:0] OP_WR_A_SET   = 5'd8;
    localparam logic [4:0] OP_WR_B_SET   = 5'd9;
    localparam logic [4:0] OP_WR_A_CLR   = 5'd10;
    localparam logic [4:0] OP_WR_B_CLR   = 5'd11;
    localparam logic [4:0] OP_WALK_INIT  = 5'd12;
    localparam logic [4:0] OP_POP        = 5'd13;
    localparam logic [4:0] OP_VISIT      = 5'd14;
    localparam logic [4:0] OP_LOAD_CAND  = 5'd15;
    localparam logic [4:0] OP_PUSH       = 5'd16;
    localparam logic [4:0] OP_FINISH     = 5'd17;

    // Wait conditions: the step stalls until this holds
    localparam logic [1:0] W_NONE = 2'd0;
    localparam logic [1:0] W_IN   = 2'd1;
    localparam logic [1:0] W_OUT  = 2'd2;
    localparam logic [1:0] W_PEND = 2'd3;

    // Branch conditions
    localparam logic [3:0] C_NEVER       = 4'd0;
    localparam logic [3:0] C_ALWAYS      = 4'd1;
    localparam logic [3:0] C_FUNC_SET    = 4'd2;
    localparam logic [3:0] C_FUNC_CLR    = 4'd3;
    localparam logic [3:0] C_FUNC_WALK   = 4'd4;
    localparam logic [3:0] C_FUNC_ACT    = 4'd5;
    localparam logic [3:0] C_BAD_SET     = 4'd6;
    localparam logic [3:0] C_BAD_AB      = 4'd7;
    localparam logic [3:0] C_BAD_A       = 4'd8;
    localparam logic [3:0] C_BAD_WALK    = 4'd9;
    localparam logic [3:0] C_EDGE_ABSENT = 4'd10;
    localparam logic [3:0] C_DIRECTED    = 4'd11;
    localparam logic [3:0] C_LIST_EMPTY  = 4'd12;
    localparam logic [3:0] C_SEEN        = 4'd13;
    localparam logic [3:0] C_CAND_NONE   = 4'd14;

    // Program step addresses
    localparam int STEP_W = 5;
    localparam logic [STEP_W-1:0] S_IDLE   = 5'd0;
    localparam logic [STEP_W-1:0] S_ERR    = 5'd5;
    localparam logic [STEP_W-1:0] S_ACT    = 5'd6;
    localparam logic [STEP_W-1:0] S_ACK    = 5'd8;
    localparam logic [STEP_W-1:0] S_SET    = 5'd9;
    localparam logic [STEP_W-1:0] S_CLR    = 5'd15;
    localparam logic [STEP_W-1:0] S_ABSENT = 5'd21;
    localparam logic [STEP_W-1:0] S_WALK   = 5'd22;
    localparam logic [STEP_W-1:0] S_POP    = 5'd24;
    localparam logic [STEP_W-1:0] S_SCAN   = 5'd29;
    localparam logic [STEP_W-1:0] S_FINISH = 5'd31;

    typedef struct packed {
        logic [4:0]        op;
        logic [1:0]        wt;
        logic [3:0]        cond;
        logic [STEP_W-1:0] target;
    } t_uword;

    // Status flags from the datapath to the sequencer
    typedef struct packed {
        logic in_valid;
        logic out_free;
        logic pend_valid;
        logic func_set;
        logic func_clr;
        logic func_walk;
        logic func_act;
        logic bad_set;
        logic bad_ab;
        logic bad_a;
        logic bad_walk;
        logic edge_absent;
        logic directed;
        logic list_empty;
        logic seen;
        logic cand_none;
    } t_flags;

    // Controls from the sequencer to the datapath
    typedef struct packed {
        logic       fire;
        logic [4:0] op;
        logic       idle;
    } t_ctrl;

    function automatic t_uword uw(input logic [4:0] op, input logic [1:0] wt,
                                  input logic [3:0] cond,
                                  input logic [STEP_W-1:0] target);
        t_uword w;
        w.op     = op;
        w.wt     = wt;
        w.cond   = cond;
        w.target = target;
        return w;
    endfunction

    // Microcode store
    function automatic t_uword ucode(input logic [STEP_W-1:0] step);
        t_uword w;
        case (step)
            // take one word and decode func
            5'd0:  w = uw(OP_LATCH,     W_IN,   C_NEVER,       S_IDLE);
            5'd1:  w = uw(OP_NONE,      W_NONE, C_FUNC_SET,    S_SET);
            5'd2:  w = uw(OP_NONE,      W_NONE, C_FUNC_CLR,    S_CLR);
            5'd3:  w = uw(OP_NONE,      W_NONE, C_FUNC_WALK,   S_WALK);
            5'd4:  w = uw(OP_NONE,      W_NONE, C_FUNC_ACT,    S_ACT);
            5'd5:  w = uw(OP_EMIT_ERR,  W_OUT,  C_ALWAYS,      S_IDLE);
            // activate / deactivate
            5'd6:  w = uw(OP_NONE,      W_NONE, C_BAD_A,       S_ERR);
            5'd7:  w = uw(OP_WR_ACTIVE, W_NONE, C_NEVER,       S_IDLE);
            5'd8:  w = uw(OP_EMIT_ACK,  W_OUT,  C_ALWAYS,      S_IDLE);
            // set edge
            5'd9:  w = uw(OP_NONE,      W_NONE, C_BAD_SET,     S_ERR);
            5'd10: w = uw(OP_RD_A,      W_NONE, C_NEVER,       S_IDLE);
            5'd11: w = uw(OP_WR_A_SET,  W_NONE, C_NEVER,       S_IDLE);
            5'd12: w = uw(OP_NONE,      W_NONE, C_DIRECTED,    S_ACK);
            5'd13: w = uw(OP_RD_B,      W_NONE, C_NEVER,       S_IDLE);
            5'd14: w = uw(OP_WR_B_SET,  W_NONE, C_ALWAYS,      S_ACK);
            // clear edge
            5'd15: w = uw(OP_NONE,      W_NONE, C_BAD_AB,      S_ERR);
            5'd16: w = uw(OP_RD_A,      W_NONE, C_NEVER,       S_IDLE);
            5'd17: w = uw(OP_NONE,      W_NONE, C_EDGE_ABSENT, S_ABSENT);
            5'd18: w = uw(OP_WR_A_CLR,  W_NONE, C_DIRECTED,    S_ACK);
            5'd19: w = uw(OP_RD_B,      W_NONE, C_NEVER,       S_IDLE);
            5'd20: w = uw(OP_WR_B_CLR,  W_NONE, C_ALWAYS,      S_ACK);
            5'd21: w = uw(OP_EMIT_ABS,  W_OUT,  C_ALWAYS,      S_IDLE);
            // walk
            5'd22: w = uw(OP_NONE,      W_NONE, C_BAD_WALK,    S_ERR);
            5'd23: w = uw(OP_WALK_INIT, W_NONE, C_NEVER,       S_IDLE);
            5'd24: w = uw(OP_NONE,      W_NONE, C_LIST_EMPTY,  S_FINISH);
            5'd25: w = uw(OP_POP,       W_NONE, C_NEVER,       S_IDLE);
            5'd26: w = uw(OP_NONE,      W_NONE, C_SEEN,        S_POP);
            5'd27: w = uw(OP_VISIT,     W_PEND, C_NEVER,       S_IDLE);
            5'd28: w = uw(OP_LOAD_CAND, W_NONE, C_NEVER,       S_IDLE);
            5'd29: w = uw(OP_NONE,      W_NONE, C_CAND_NONE,   S_POP);
            5'd30: w = uw(OP_PUSH,      W_NONE, C_ALWAYS,      S_SCAN);
            5'd31: w = uw(OP_FINISH,    W_OUT,  C_ALWAYS,      S_IDLE);
            default: w = uw(OP_NONE,    W_NONE, C_ALWAYS,      S_IDLE);
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/amgt_seq.sv =====
// Microcode sequencer: step counter, control store, wait and branch logic.
`timescale 1ns / 1ps
`default_nettype none

module amgt_seq
    import amgt_pkg::*;
(
    input  wire    i_clk,
    input  wire    i_rst_n,
    input  t_flags i_flags,
    output t_ctrl  o_ctrl
);

    logic [STEP_W-1:0] r_step;
    logic [STEP_W-1:0] n_step;
    t_uword            w;
    logic              ready;
    logic              taken;

    assign w = ucode(r_step);

    // wait gate
    always_comb begin
        case (w.wt)
            W_NONE:  ready = 1'b1;
            W_IN:    ready = i_flags.in_valid;
            W_OUT:   ready = i_flags.out_free;
            W_PEND:  ready = !i_flags.pend_valid || i_flags.out_free;
            default: ready = 1'b1;
        endcase
    end

    // branch condition select
    always_comb begin
        case (w.cond)
            C_NEVER:       taken = 1'b0;
            C_ALWAYS:      taken = 1'b1;
            C_FUNC_SET:    taken = i_flags.func_set;
            C_FUNC_CLR:    taken = i_flags.func_clr;
            C_FUNC_WALK:   taken = i_flags.func_walk;
            C_FUNC_ACT:    taken = i_flags.func_act;
            C_BAD_SET:     taken = i_flags.bad_set;
            C_BAD_AB:      taken = i_flags.bad_ab;
            C_BAD_A:       taken = i_flags.bad_a;
            C_BAD_WALK:    taken = i_flags.bad_walk;
            C_EDGE_ABSENT: taken = i_flags.edge_absent;
            C_DIRECTED:    taken = i_flags.directed;
            C_LIST_EMPTY:  taken = i_flags.list_empty;
            C_SEEN:        taken = i_flags.seen;
            C_CAND_NONE:   taken = i_flags.cand_none;
            default:       taken = 1'b0;
        endcase
    end

    // next step
    always_comb begin
        if (!ready) begin
            n_step = r_step;
        end else if (taken) begin
            n_step = w.target;
        end else begin
            n_step = r_step + STEP_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= S_IDLE;
        end else begin
            r_step <= n_step;
        end
    end

    assign o_ctrl.fire = ready;
    assign o_ctrl.op   = w.op;
    assign o_ctrl.idle = (r_step == S_IDLE);

endmodule

`default_nettype wire

// ===== hw/rtl/adjacency_matrix_graph_traversal.sv =====
// Top level: adjacency matrix store with breadth-first and depth-first walks.
//
// Input channel (i_valid / o_stall) takes one word: func, vertex_a, vertex_b.
// Output channel (o_valid / i_stall) gives result words: visited_vertex,
// status and last; last marks the final word of each input word.
// Config channel (i_cfg_valid / o_cfg_ready, always ready): index 0 is
// directed_mode, index 1 is vertex_count. Write only while the block is idle.
// A microcoded sequencer runs one control word per cycle over a plain
// datapath, holding a step while its wait condition is false; o_stall is
// low only in the idle step. The row scan of a walk pushes the lowest set
// candidate bit first.
// One visit is held back until the next is found, so last can be set.
// When the receiver stalls, the output register holds and the sequencer
// waits at its next emit step; other steps keep running.
// Reset clears the matrix (per-row valid bits), flags, config and control.

`timescale 1ns / 1ps
`default_nettype none

module adjacency_matrix_graph_traversal
    import amgt_pkg::*;
(
    input  wire        i_clk,
    input  wire        i_rst_n,
    // input words
    input  wire        i_valid,
    output logic       o_stall,
    input  wire  [2:0] i_func,
    input  wire  [3:0] i_vertex_a,
    input  wire  [3:0] i_vertex_b,
    // result words
    output logic       o_valid,
    input  wire        i_stall,
    output logic [3:0] o_visited_vertex,
    output logic [1:0] o_status,
    output logic       o_last,
    // configuration
    input  wire        i_cfg_valid,
    output logic       o_cfg_ready,
    input  wire        i_cfg_index,
    input  wire  [4:0] i_cfg_data
);

    t_flags flags;
    t_ctrl  ctrl;

    // config registers
    logic             r_directed;
    logic [CNT_W-1:0] r_count;

    // latched word
    logic [2:0] r_func;
    t_vtx       r_a;
    t_vtx       r_b;

    // graph state
    t_row adj_mem [MAX_VERTICES];
    t_row r_row_vld;
    t_row r_row_rd;
    t_row r_active;

    // walk state
    t_vtx             work_mem [WORK_DEPTH];
    t_vtx             r_cur;
    t_row             r_visited;
    t_row             r_cand;
    logic [PTR_W-1:0] r_head;
    logic [PTR_W-1:0] r_tail;
    logic             r_pend_valid;
    t_vtx             r_pend_v;

    logic             out_free;
    logic [CNT_W-1:0] slots;
    t_row             slot_mask;
    logic             a_ok;
    logic             b_ok;
    logic             a_act;
    logic             b_act;
    logic             is_dfs;
    t_vtx             push_v;

    logic             emit;
    t_vtx             emit_v;
    logic [1:0]       emit_st;
    logic             emit_last;

    logic             mat_rd;
    t_vtx             mat_rd_addr;
    logic             mat_wr;
    t_vtx             mat_wr_addr;
    t_row             mat_wr_data;

    logic                 wl_wr;
    logic [WORK_AW-1:0]   wl_wr_addr;
    t_vtx                 wl_wr_data;
    logic                 wl_rd;
    logic [WORK_AW-1:0]   wl_rd_addr;
    logic [PTR_W-1:0]     tail_m1;

    assign o_stall     = !ctrl.idle;
    assign o_cfg_ready = 1'b1;
    assign out_free    = !o_valid || !i_stall;
    assign is_dfs      = r_func[0];
    assign tail_m1     = r_tail - PTR_W'(1);

    // slot range and validity checks
    always_comb begin
        slots = (r_count > CNT_W'(MAX_VERTICES)) ? CNT_W'(MAX_VERTICES) : r_count;
        for (int i = 0; i < MAX_VERTICES; i++) begin
            slot_mask[i] = (CNT_W'(i) < slots);
        end
        a_ok  = ({1'b0, r_a} < slots);
        b_ok  = ({1'b0, r_b} < slots);
        a_act = a_ok && r_active[r_a];
        b_act = b_ok && r_active[r_b];
    end

    // lowest candidate neighbor
    always_comb begin
        push_v = '0;
        for (int i = MAX_VERTICES - 1; i >= 0; i--) begin
            if (r_cand[i]) begin
                push_v = VTX_W'(i);
            end
        end
    end

    // flags to the sequencer
    always_comb begin
        flags.in_valid    = i_valid;
        flags.out_free    = out_free;
        flags.pend_valid  = r_pend_valid;
        flags.func_set    = (r_func == FN_SET_EDGE);
        flags.func_clr    = (r_func == FN_CLR_EDGE);
        flags.func_walk   = r_func inside {FN_BFS, FN_DFS};
        flags.func_act    = r_func inside {FN_ACTIVATE, FN_DEACT};
        flags.bad_set     = !(a_act && b_act);
        flags.bad_ab      = !(a_ok && b_ok);
        flags.bad_a       = !a_ok;
        flags.bad_walk    = !a_act;
        flags.edge_absent = !r_row_rd[r_b];
        flags.directed    = r_directed;
        flags.list_empty  = !(r_head < r_tail);
        flags.seen        = r_visited[r_cur];
        flags.cand_none   = (r_cand == '0);
    end

    amgt_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_flags (flags),
        .o_ctrl  (ctrl)
    );

    // datapath decode of the current control word
    always_comb begin
        emit        = 1'b0;
        emit_v      = '0;
        emit_st     = ST_ACK;
        emit_last   = 1'b1;
        mat_rd      = 1'b0;
        mat_rd_addr = r_a;
        mat_wr      = 1'b0;
        mat_wr_addr = r_a;
        mat_wr_data = r_row_rd;
        wl_wr       = 1'b0;
        wl_wr_addr  = r_tail[WORK_AW-1:0];
        wl_wr_data  = push_v;
        wl_rd       = 1'b0;
        wl_rd_addr  = is_dfs ? tail_m1[WORK_AW-1:0] : r_head[WORK_AW-1:0];
        if (ctrl.fire) begin
            case (ctrl.op)
                OP_EMIT_ERR: begin
                    emit    = 1'b1;
                    emit_st = ST_BADVTX;
                end
                OP_EMIT_ACK: begin
                    emit    = 1'b1;
                    emit_st = ST_ACK;
                end
                OP_EMIT_ABS: begin
                    emit    = 1'b1;
                    emit_st = ST_ABSENT;
                end
                OP_RD_A: begin
                    mat_rd = 1'b1;
                end
                OP_RD_B: begin
                    mat_rd      = 1'b1;
                    mat_rd_addr = r_b;
                end
                OP_WR_A_SET: begin
                    mat_wr      = 1'b1;
                    mat_wr_data = r_row_rd | (t_row'(1) << r_b);
                end
                OP_WR_B_SET: begin
                    mat_wr      = 1'b1;
                    mat_wr_addr = r_b;
                    mat_wr_data = r_row_rd | (t_row'(1) << r_a);
                end
                OP_WR_A_CLR: begin
                    mat_wr      = 1'b1;
                    mat_wr_data = r_row_rd & ~(t_row'(1) << r_b);
                end
                OP_WR_B_CLR: begin
                    mat_wr      = 1'b1;
                    mat_wr_addr = r_b;
                    mat_wr_data = r_row_rd & ~(t_row'(1) << r_a);
                end
                OP_WALK_INIT: begin
                    wl_wr      = 1'b1;
                    wl_wr_addr = '0;
                    wl_wr_data = r_a;
                end
                OP_POP: begin
                    wl_rd = 1'b1;
                end
                OP_VISIT: begin
                    mat_rd      = 1'b1;
                    mat_rd_addr = r_cur;
                    emit        = r_pend_valid;
                    emit_v      = r_pend_v;
                    emit_st     = ST_VISIT;
                    emit_last   = 1'b0;
                end
                OP_PUSH: begin
                    wl_wr = (r_tail < PTR_W'(WORK_DEPTH));
                end
                OP_FINISH: begin
                    emit    = 1'b1;
                    emit_v  = r_pend_v;
                    emit_st = ST_VISIT;
                end
                default: begin
                end
            endcase
        end
    end

    // adjacency matrix memory, registered read; a row not written since reset reads empty
    always_ff @(posedge i_clk) begin
        if (mat_wr) begin
            adj_mem[mat_wr_addr] <= mat_wr_data;
        end
        if (mat_rd) begin
            r_row_rd <= r_row_vld[mat_rd_addr] ? adj_mem[mat_rd_addr] : '0;
        end
    end

    // work list memory, registered read
    always_ff @(posedge i_clk) begin
        if (wl_wr) begin
            work_mem[wl_wr_addr] <= wl_wr_data;
        end
        if (wl_rd) begin
            r_cur <= work_mem[wl_rd_addr];
        end
    end

    // control and flag registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_directed   <= 1'b0;
            r_count      <= '0;
            r_row_vld    <= '0;
            r_active     <= '0;
            r_visited    <= '0;
            r_head       <= '0;
            r_tail       <= '0;
            r_pend_valid <= 1'b0;
            o_valid      <= 1'b0;
        end else begin
            // configuration writes
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_DIRECTED: r_directed <= i_cfg_data[0];
                    CFG_COUNT:    r_count    <= i_cfg_data;
                    default:      r_count    <= r_count;
                endcase
            end
            if (mat_wr) begin
                r_row_vld[mat_wr_addr] <= 1'b1;
            end
            // output register
            if (emit) begin
                o_valid <= 1'b1;
            end else if (o_valid && !i_stall) begin
                o_valid <= 1'b0;
            end
            if (ctrl.fire) begin
                case (ctrl.op)
                    OP_WR_ACTIVE: begin
                        r_active[r_a] <= !r_func[0];
                    end
                    OP_WALK_INIT: begin
                        r_visited    <= '0;
                        r_head       <= '0;
                        r_tail       <= PTR_W'(1);
                        r_pend_valid <= 1'b0;
                    end
                    OP_POP: begin
                        if (is_dfs) begin
                            r_tail <= tail_m1;
                        end else begin
                            r_head <= r_head + PTR_W'(1);
                        end
                    end
                    OP_VISIT: begin
                        r_visited[r_cur] <= 1'b1;
                        r_pend_valid     <= 1'b1;
                    end
                    OP_PUSH: begin
                        if (r_tail < PTR_W'(WORK_DEPTH)) begin
                            r_tail <= r_tail + PTR_W'(1);
                        end
                    end
                    OP_FINISH: begin
                        r_pend_valid <= 1'b0;
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (ctrl.fire && ctrl.op == OP_LATCH) begin
            r_func <= i_func;
            r_a    <= i_vertex_a;
            r_b    <= i_vertex_b;
        end
        if (ctrl.fire && ctrl.op == OP_VISIT) begin
            r_pend_v <= r_cur;
        end
        if (ctrl.fire && ctrl.op == OP_LOAD_CAND) begin
            // unvisited neighbors in the live slots
            r_cand <= r_row_rd & ~r_visited & slot_mask;
        end else if (ctrl.fire && ctrl.op == OP_PUSH) begin
            r_cand <= r_cand & (r_cand - t_row'(1));
        end
        if (emit) begin
            o_visited_vertex <= emit_v;
            o_status         <= emit_st;
            o_last           <= emit_last;
        end
    end

endmodule

`default_nettype wire

// ===== verif/tb.sv =====
// Testbench for the graph traversal block: directed cases, random phases, output back-pressure.
`timescale 1ns / 1ps

module tb;
    import amgt_pkg::*;

    // func codes the block does not define
    localparam logic [2:0] FN_SPARE_A = 3'd6;
    localparam logic [2:0] FN_SPARE_B = 3'd7;

    localparam int IDLE_SETTLE  = 12;    // a result-less tail after the last word
    localparam int END_SETTLE   = 40;
    localparam int HOLD_CYCLES  = 300;   // long receiver hold-off
    localparam int QUIET_LIMIT  = 4000;  // cycles with no handshake at all
    localparam int MAX_REPORTS  = 10;

    typedef struct packed {
        t_vtx       vertex;
        logic [1:0] status;
        logic       last;
    } t_graph_result;

    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       i_valid     = 1'b0;
    logic [2:0] i_func      = '0;
    logic [3:0] i_vertex_a  = '0;
    logic [3:0] i_vertex_b  = '0;
    logic       i_stall     = 1'b0;
    logic       i_cfg_valid = 1'b0;
    logic       i_cfg_index = 1'b0;
    logic [4:0] i_cfg_data  = '0;
    logic       o_stall;
    logic       o_valid;
    logic [3:0] o_visited_vertex;
    logic [1:0] o_status;
    logic       o_last;
    logic       o_cfg_ready;

    // shared run control
    logic hold_off  = 1'b0;
    logic calm_mode = 1'b0;
    int   mismatch_count = 0;
    int   quiet_cycles   = 0;

    // mirror of the graph state and registers
    t_row       adj_rows [MAX_VERTICES];
    t_row       vertex_on     = '0;
    logic       directed_mode = 1'b0;
    logic [4:0] vertex_count  = '0;

    t_graph_result expected_words [$];

    adjacency_matrix_graph_traversal u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_func           (i_func),
        .i_vertex_a       (i_vertex_a),
        .i_vertex_b       (i_vertex_b),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_visited_vertex (o_visited_vertex),
        .o_status         (o_status),
        .o_last           (o_last),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    initial begin
        for (int r = 0; r < MAX_VERTICES; r++) adj_rows[r] = '0;
    end

    // ---------------------------------------------------------------- predictor

    function automatic int slot_total();
        return (vertex_count > MAX_VERTICES) ? MAX_VERTICES : int'(vertex_count);
    endfunction

    function automatic t_vtx pick_slot(int n);
        return t_vtx'($urandom_range(n - 1));
    endfunction

    function automatic void add_word(t_vtx v, logic [1:0] st, logic lst);
        t_graph_result w;
        w.vertex = v;
        w.status = st;
        w.last   = lst;
        expected_words.push_back(w);
    endfunction

    // Walk with a work list that keeps duplicates; visited is checked on removal.
    // One visit is held back so the final one can carry last.
    function automatic void predict_walk(t_vtx start, logic depth_first);
        t_vtx work [WORK_DEPTH];
        int   head;
        int   tail;
        int   n;
        t_row seen;
        t_vtx cur;
        t_vtx held;
        logic have_held;
        n         = slot_total();
        seen      = '0;
        head      = 0;
        work[0]   = start;
        tail      = 1;
        have_held = 1'b0;
        held      = '0;
        while (head < tail) begin
            if (depth_first) begin
                tail = tail - 1;
                cur  = work[tail];
            end else begin
                cur  = work[head];
                head = head + 1;
            end
            if (seen[cur]) continue;
            seen[cur] = 1'b1;
            if (have_held) add_word(held, ST_VISIT, 1'b0);
            held      = cur;
            have_held = 1'b1;
            // neighbors in ascending index; a full list drops the push
            for (int i = 0; i < n; i++) begin
                if (adj_rows[cur][i] && !seen[i] && tail < WORK_DEPTH) begin
                    work[tail] = t_vtx'(i);
                    tail       = tail + 1;
                end
            end
        end
        add_word(held, ST_VISIT, 1'b1);
    endfunction

    function automatic void graph_step(logic [2:0] fn, t_vtx a, t_vtx b);
        int   n;
        logic a_ok;
        logic b_ok;
        logic a_on;
        logic b_on;
        n    = slot_total();
        a_ok = int'(a) < n;
        b_ok = int'(b) < n;
        a_on = a_ok && vertex_on[a];
        b_on = b_ok && vertex_on[b];
        case (fn)
            FN_SET_EDGE: begin
                if (!a_on || !b_on) begin
                    add_word('0, ST_BADVTX, 1'b1);
                end else begin
                    adj_rows[a][b] = 1'b1;
                    if (!directed_mode) adj_rows[b][a] = 1'b1;
                    add_word('0, ST_ACK, 1'b1);
                end
            end
            FN_CLR_EDGE: begin
                if (!a_ok || !b_ok) begin
                    add_word('0, ST_BADVTX, 1'b1);
                end else if (!adj_rows[a][b]) begin
                    add_word('0, ST_ABSENT, 1'b1);
                end else begin
                    adj_rows[a][b] = 1'b0;
                    if (!directed_mode) adj_rows[b][a] = 1'b0;
                    add_word('0, ST_ACK, 1'b1);
                end
            end
            FN_BFS, FN_DFS: begin
                if (!a_on) add_word('0, ST_BADVTX, 1'b1);
                else       predict_walk(a, fn == FN_DFS);
            end
            FN_ACTIVATE, FN_DEACT: begin
                if (!a_ok) begin
                    add_word('0, ST_BADVTX, 1'b1);
                end else begin
                    vertex_on[a] = (fn == FN_ACTIVATE);
                    add_word('0, ST_ACK, 1'b1);
                end
            end
            default: add_word('0, ST_BADVTX, 1'b1);
        endcase
    endfunction

    // ---------------------------------------------------------------- drivers

    // Valid stays high after acceptance; the next call either reloads it at once
    // or drops it for a gap.
    task automatic send_word(logic [2:0] fn, t_vtx a, t_vtx b);
        while (!calm_mode && $urandom_range(99) < 22) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid    <= 1'b1;
        i_func     <= fn;
        i_vertex_a <= a;
        i_vertex_b <= b;
        do @(posedge i_clk); while (o_stall);
        graph_step(fn, a, b);
    endtask

    task automatic wait_idle(int settle);
        i_valid <= 1'b0;
        while (expected_words.size() != 0) @(posedge i_clk);
        repeat (settle) @(posedge i_clk);
    endtask

    // Both registers, written back to back once the block has gone quiet.
    task automatic configure(logic dir, logic [4:0] cnt);
        logic [4:0] dir_word;
        dir_word = {4'($urandom_range(15)), dir};
        wait_idle(IDLE_SETTLE);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= CFG_DIRECTED;
        i_cfg_data  <= dir_word;
        do @(posedge i_clk); while (!o_cfg_ready);
        directed_mode = dir_word[0];
        i_cfg_index <= CFG_COUNT;
        i_cfg_data  <= cnt;
        do @(posedge i_clk); while (!o_cfg_ready);
        vertex_count = cnt;
        i_cfg_valid <= 1'b0;
    endtask

    // Receiver stall and result check.
    always @(posedge i_clk) begin : check_results
        t_graph_result want;
        if (hold_off)       i_stall <= 1'b1;
        else if (calm_mode) i_stall <= 1'b0;
        else                i_stall <= ($urandom_range(99) < 22);

        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_words.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("unexpected result word: vertex %0d status %0d last %0d",
                             o_visited_vertex, o_status, o_last);
            end else begin
                want = expected_words.pop_front();
                if (want.vertex !== o_visited_vertex || want.status !== o_status ||
                    want.last !== o_last) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display({"result mismatch: expected vertex %0d status %0d last %0d,",
                                  " got vertex %0d status %0d last %0d"},
                                 want.vertex, want.status, want.last,
                                 o_visited_vertex, o_status, o_last);
                end
            end
        end
    end

    // Watchdog: any handshake restarts the count.
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || (i_cfg_valid && o_cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin : watchdog
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("Verification failed");
        $finish;
    end

    // ---------------------------------------------------------------- tests

    // Out of reset no slot is in use, so everything is rejected.
    task automatic test_reset_state();
        send_word(FN_ACTIVATE, 4'd0, 4'd0);
        send_word(FN_BFS, 4'd0, 4'd0);
    endtask

    task automatic test_vertex_flags();
        configure(1'b0, 5'd16);
        send_word(FN_ACTIVATE, 4'd0, 4'd15);
        send_word(FN_ACTIVATE, 4'd1, 4'd0);
        send_word(FN_ACTIVATE, 4'd2, 4'd0);
        send_word(FN_ACTIVATE, 4'd3, 4'd0);
        send_word(FN_ACTIVATE, 4'd15, 4'd0);
        send_word(FN_DEACT, 4'd15, 4'd0);
        send_word(FN_ACTIVATE, 4'd15, 4'd0);
        send_word(FN_ACTIVATE, 4'd15, 4'd0);    // already set, still acked
    endtask

    task automatic test_edge_ops();
        send_word(FN_SET_EDGE, 4'd0, 4'd1);
        send_word(FN_SET_EDGE, 4'd0, 4'd2);
        send_word(FN_SET_EDGE, 4'd1, 4'd3);
        send_word(FN_SET_EDGE, 4'd2, 4'd3);
        send_word(FN_SET_EDGE, 4'd3, 4'd15);
        send_word(FN_SET_EDGE, 4'd0, 4'd4);     // inactive destination
        send_word(FN_CLR_EDGE, 4'd1, 4'd2);     // absent edge
        send_word(FN_CLR_EDGE, 4'd3, 4'd2);     // clears the mirrored copy
        send_word(FN_SPARE_A, 4'd15, 4'd15);
        send_word(FN_SPARE_B, 4'd0, 4'd0);
    endtask

    task automatic test_walks();
        send_word(FN_BFS, 4'd0, 4'd0);
        send_word(FN_DFS, 4'd0, 4'd15);
        send_word(FN_BFS, 4'd4, 4'd0);          // inactive start
        send_word(FN_DEACT, 4'd3, 4'd0);
        send_word(FN_DFS, 4'd15, 4'd0);         // passes through inactive vertex 3
    endtask

    // Shrinking the count hides edges to slots beyond it.
    task automatic test_slot_limit();
        configure(1'b1, 5'd3);
        send_word(FN_BFS, 4'd0, 4'd0);
        send_word(FN_CLR_EDGE, 4'd0, 4'd15);
        send_word(FN_ACTIVATE, 4'd3, 4'd0);
    endtask

    // Mostly well-formed graph work with a share of noise words.
    task automatic test_random_phase(logic dir, logic [4:0] cnt, int items);
        int n;
        int pick;
        configure(dir, cnt);
        n = slot_total();
        for (int v = 0; v < n; v++)
            send_word(FN_ACTIVATE, t_vtx'(v), t_vtx'($urandom_range(15)));
        for (int k = 0; k < items; k++) begin
            pick = $urandom_range(99);
            if (pick < 12)
                send_word(3'($urandom_range(7)), t_vtx'($urandom_range(15)),
                          t_vtx'($urandom_range(15)));
            else if (pick < 42)
                send_word(FN_SET_EDGE, pick_slot(n), pick_slot(n));
            else if (pick < 52)
                send_word(FN_CLR_EDGE, pick_slot(n), pick_slot(n));
            else if (pick < 62)
                send_word(FN_BFS, pick_slot(n), t_vtx'($urandom_range(15)));
            else if (pick < 72)
                send_word(FN_DFS, pick_slot(n), t_vtx'($urandom_range(15)));
            else if (pick < 80)
                send_word(FN_DEACT, pick_slot(n), t_vtx'($urandom_range(15)));
            else
                send_word(FN_ACTIVATE, pick_slot(n), t_vtx'($urandom_range(15)));
        end
    endtask

    // No idling on either side for a whole phase.
    task automatic test_steady_flow();
        calm_mode <= 1'b1;
        test_random_phase(1'b1, 5'd7, 4);
        calm_mode <= 1'b0;
    endtask

    // Receiver holds off while walks keep coming, so the block backs up.
    task automatic test_backpressure();
        configure(1'b0, 5'd16);
        for (int v = 0; v < MAX_VERTICES; v++) send_word(FN_ACTIVATE, t_vtx'(v), 4'd0);
        repeat (8) send_word(FN_SET_EDGE, pick_slot(MAX_VERTICES), pick_slot(MAX_VERTICES));
        fork
            begin
                hold_off <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_off <= 1'b0;
            end
            repeat (6)
                send_word(($urandom_range(1) != 0) ? FN_BFS : FN_DFS,
                          pick_slot(MAX_VERTICES), 4'd0);
        join
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_state();
        test_vertex_flags();
        test_edge_ops();
        test_walks();
        test_slot_limit();
        test_random_phase(1'b0, 5'd16, 4);
        test_random_phase(1'b1, 5'd31, 4);
        test_random_phase(1'b0, 5'd2, 4);
        test_steady_flow();
        test_backpressure();

        wait_idle(END_SETTLE);
        if (mismatch_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
